[rtl/vpp_pkg.sv]
// shared types and constants for the vertex perspective projection block
package vpp_pkg;

   localparam int FRAC_BITS_DEFAULT   = 16;
   localparam int COORD_WIDTH_DEFAULT = 32;
   localparam int FIELD_W             = 32;
   localparam int PIXEL_W             = 16;
   localparam int VIEWPORT_W          = 12;
   localparam int CSR_INDEX_W         = 3;

   localparam int LANES  = 3;
   localparam int LANE_X = 0;
   localparam int LANE_Y = 1;
   localparam int LANE_Z = 2;

   localparam logic [VIEWPORT_W-1:0] VIEWPORT_WIDTH_RESET  = VIEWPORT_W'(320);
   localparam logic [VIEWPORT_W-1:0] VIEWPORT_HEIGHT_RESET = VIEWPORT_W'(200);

   typedef logic signed [FIELD_W-1:0] field_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_X_SCALE,
      CSR_Y_SCALE,
      CSR_Y_FROM_DEPTH,
      CSR_DEPTH_FROM_X,
      CSR_DEPTH_SCALE,
      CSR_DEPTH_OFFSET,
      CSR_VIEWPORT_WIDTH,
      CSR_VIEWPORT_HEIGHT
   } csr_index_type;

   typedef struct packed {
      field_type x_scale;
      field_type y_scale;
      field_type y_from_depth;
      field_type depth_from_x;
      field_type depth_scale;
      field_type depth_offset;
   } matrix_type;

   // travels alongside each vertex through the pipeline
   typedef struct packed {
      logic      valid;
      logic      w_zero;
      field_type w;
   } vtx_side_type;

endpackage

[rtl/vpp_req_if.sv]
// vertex input channel
interface vpp_req_if import vpp_pkg::*; ();
   logic      valid;
   logic      ready;
   field_type vertex_x;
   field_type vertex_y;
   field_type vertex_z;

   modport source (output valid, output vertex_x, output vertex_y, output vertex_z,
                   input ready);
   modport sink (input valid, input vertex_x, input vertex_y, input vertex_z,
                 output ready);
endinterface

[rtl/vpp_rsp_if.sv]
// projected vertex result channel
interface vpp_rsp_if import vpp_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [PIXEL_W-1:0] pixel_x;
   logic signed [PIXEL_W-1:0] pixel_y;
   field_type                 depth_out;
   field_type                 clip_w;
   logic                      w_was_zero;

   modport source (output valid, output pixel_x, output pixel_y, output depth_out,
                   output clip_w, output w_was_zero, input ready);
   modport sink (input valid, input pixel_x, input pixel_y, input depth_out,
                 input clip_w, input w_was_zero, output ready);
endinterface

[rtl/vpp_csr_if.sv]
// configuration register write channel
interface vpp_csr_if import vpp_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [FIELD_W-1:0]     data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/vpp_transform.sv]
// matrix multiply stage and clip sum stage
module vpp_transform import vpp_pkg::*; #(
   parameter int FRAC_BITS   = FRAC_BITS_DEFAULT,
   parameter int COORD_WIDTH = COORD_WIDTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic                          in_valid,
   input  field_type                     vertex_x,
   input  field_type                     vertex_y,
   input  field_type                     vertex_z,
   input  matrix_type                    matrix,
   output vtx_side_type                  side_out,
   output logic signed [COORD_WIDTH-1:0] clip_out [LANES]
);

   localparam int PROD_W = 2 * FIELD_W;
   localparam int ACC_W  = PROD_W + 2;
   localparam logic signed [ACC_W-1:0] COORD_MAX = (ACC_W'(1) <<< (COORD_WIDTH - 1)) - ACC_W'(1);
   localparam logic signed [ACC_W-1:0] COORD_MIN = -COORD_MAX - ACC_W'(1);
   localparam field_type FIELD_MAX = {1'b0, {(FIELD_W-1){1'b1}}};
   localparam field_type FIELD_MIN = {1'b1, {(FIELD_W-1){1'b0}}};

   function automatic logic signed [COORD_WIDTH-1:0] sat_coord(
      input logic signed [ACC_W-1:0] v
   );
      logic signed [COORD_WIDTH-1:0] r;
      if (v > COORD_MAX) begin
         r = COORD_MAX[COORD_WIDTH-1:0];
      end else if (v < COORD_MIN) begin
         r = COORD_MIN[COORD_WIDTH-1:0];
      end else begin
         r = v[COORD_WIDTH-1:0];
      end
      return r;
   endfunction

   // stage 1: products
   vtx_side_type             side1_in, side1_ff;
   logic signed [PROD_W-1:0] prod_xx_in, prod_yy_in, prod_zy_in, prod_xz_in, prod_zz_in;
   logic signed [PROD_W-1:0] prod_xx_ff, prod_yy_ff, prod_zy_ff, prod_xz_ff, prod_zz_ff;

   always_comb begin
      side1_in.valid  = in_valid;
      side1_in.w_zero = (vertex_z == '0);
      side1_in.w      = (vertex_z == FIELD_MIN) ? FIELD_MAX : -vertex_z;
      prod_xx_in = $signed(vertex_x) * $signed(matrix.x_scale);
      prod_yy_in = $signed(vertex_y) * $signed(matrix.y_scale);
      prod_zy_in = $signed(vertex_z) * $signed(matrix.y_from_depth);
      prod_xz_in = $signed(vertex_x) * $signed(matrix.depth_from_x);
      prod_zz_in = $signed(vertex_z) * $signed(matrix.depth_scale);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side1_ff.valid <= 1'b0;
      end else if (advance) begin
         side1_ff <= side1_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_xx_ff <= prod_xx_in;
         prod_yy_ff <= prod_yy_in;
         prod_zy_ff <= prod_zy_in;
         prod_xz_ff <= prod_xz_in;
         prod_zz_ff <= prod_zz_in;
      end
   end

   // stage 2: floor to fixed point and saturate
   logic signed [ACC_W-1:0]       sum_x, sum_y, sum_z;
   logic signed [COORD_WIDTH-1:0] clip_in [LANES];
   vtx_side_type                  side2_ff;
   logic signed [COORD_WIDTH-1:0] clip_ff [LANES];

   always_comb begin
      sum_x = ACC_W'(prod_xx_ff) >>> FRAC_BITS;
      sum_y = (ACC_W'(prod_yy_ff) + ACC_W'(prod_zy_ff)) >>> FRAC_BITS;
      sum_z = ((ACC_W'(prod_xz_ff) + ACC_W'(prod_zz_ff)) >>> FRAC_BITS)
              + ACC_W'($signed(matrix.depth_offset));
      clip_in[LANE_X] = sat_coord(sum_x);
      clip_in[LANE_Y] = sat_coord(sum_y);
      clip_in[LANE_Z] = sat_coord(sum_z);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side2_ff.valid <= 1'b0;
      end else if (advance) begin
         side2_ff <= side1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int l = 0; l < LANES; l++) begin
            clip_ff[l] <= clip_in[l];
         end
      end
   end

   assign side_out = side2_ff;
   assign clip_out = clip_ff;

endmodule

[rtl/vpp_divider.sv]
// pipelined restoring divider, one quotient bit per stage, three lanes sharing w
module vpp_divider import vpp_pkg::*; #(
   parameter int FRAC_BITS   = FRAC_BITS_DEFAULT,
   parameter int COORD_WIDTH = COORD_WIDTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  vtx_side_type                  side_in,
   input  logic signed [COORD_WIDTH-1:0] clip_in [LANES],
   output vtx_side_type                  side_out,
   output logic signed [COORD_WIDTH-1:0] quot_out [LANES]
);

   localparam int STEPS = COORD_WIDTH;
   localparam int REM_W = FIELD_W - 1;
   localparam int NUM_W = COORD_WIDTH + FRAC_BITS;
   localparam int CMP_W = (FRAC_BITS > REM_W) ? FRAC_BITS : REM_W;
   localparam logic [COORD_WIDTH-1:0] LIMIT   = {1'b1, {(COORD_WIDTH-1){1'b0}}};
   localparam logic [COORD_WIDTH-1:0] POS_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};

   vtx_side_type           side_ff    [STEPS+1];
   logic [REM_W-1:0]       divisor_ff [STEPS+1];
   logic [REM_W-1:0]       rem_ff     [STEPS+1][LANES];
   logic [COORD_WIDTH-1:0] dq_ff      [STEPS+1][LANES];
   logic                   ovf_ff     [STEPS+1][LANES];
   logic                   neg_ff     [STEPS+1][LANES];

   // prep stage: magnitudes, top dividend bits, overflow check
   logic [FIELD_W-1:0]     w_mag;
   logic [REM_W-1:0]       divisor_in;
   logic [COORD_WIDTH-1:0] mag_c   [LANES];
   logic [NUM_W-1:0]       num     [LANES];
   logic [FRAC_BITS-1:0]   num_hi  [LANES];
   logic [REM_W-1:0]       rem_in  [LANES];
   logic [COORD_WIDTH-1:0] dq_in   [LANES];
   logic                   ovf_in  [LANES];
   logic                   neg_in  [LANES];

   always_comb begin
      w_mag      = side_in.w[FIELD_W-1] ? (~side_in.w) + FIELD_W'(1) : side_in.w;
      divisor_in = w_mag[REM_W-1:0];
      for (int l = 0; l < LANES; l++) begin
         mag_c[l]  = clip_in[l][COORD_WIDTH-1] ? (~clip_in[l]) + COORD_WIDTH'(1)
                                               : clip_in[l];
         num[l]    = {mag_c[l], {FRAC_BITS{1'b0}}};
         num_hi[l] = num[l][NUM_W-1 -: FRAC_BITS];
         ovf_in[l] = CMP_W'(num_hi[l]) >= CMP_W'(divisor_in);
         rem_in[l] = REM_W'(num_hi[l]);
         neg_in[l] = clip_in[l][COORD_WIDTH-1] ^ side_in.w[FIELD_W-1];
         // zero w: the clip value rides through untouched
         dq_in[l]  = side_in.w_zero ? $unsigned(clip_in[l]) : num[l][COORD_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff[0].valid <= 1'b0;
      end else if (advance) begin
         side_ff[0] <= side_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         divisor_ff[0] <= divisor_in;
         for (int l = 0; l < LANES; l++) begin
            rem_ff[0][l] <= rem_in[l];
            dq_ff[0][l]  <= dq_in[l];
            ovf_ff[0][l] <= ovf_in[l];
            neg_ff[0][l] <= neg_in[l];
         end
      end
   end

   // quotient bit stages
   for (genvar s = 1; s <= STEPS; s++) begin : g_step
      logic [REM_W:0]         trial       [LANES];
      logic                   take        [LANES];
      logic [REM_W-1:0]       step_rem_in [LANES];
      logic [COORD_WIDTH-1:0] step_dq_in  [LANES];

      always_comb begin
         for (int l = 0; l < LANES; l++) begin
            trial[l] = {rem_ff[s-1][l], dq_ff[s-1][l][COORD_WIDTH-1]};
            take[l]  = trial[l] >= (REM_W+1)'(divisor_ff[s-1]);
            if (side_ff[s-1].w_zero) begin
               step_rem_in[l] = rem_ff[s-1][l];
               step_dq_in[l]  = dq_ff[s-1][l];
            end else begin
               step_rem_in[l] = take[l] ? REM_W'(trial[l] - (REM_W+1)'(divisor_ff[s-1]))
                                        : trial[l][REM_W-1:0];
               step_dq_in[l]  = {dq_ff[s-1][l][COORD_WIDTH-2:0], take[l]};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            side_ff[s].valid <= 1'b0;
         end else if (advance) begin
            side_ff[s] <= side_ff[s-1];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            divisor_ff[s] <= divisor_ff[s-1];
            for (int l = 0; l < LANES; l++) begin
               rem_ff[s][l] <= step_rem_in[l];
               dq_ff[s][l]  <= step_dq_in[l];
               ovf_ff[s][l] <= ovf_ff[s-1][l];
               neg_ff[s][l] <= neg_ff[s-1][l];
            end
         end
      end
   end

   // final stage: sign and saturation
   logic                          big     [LANES];
   logic signed [COORD_WIDTH-1:0] quot_in [LANES];
   logic signed [COORD_WIDTH-1:0] quot_ff [LANES];
   vtx_side_type                  side_fin_ff;

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         big[l] = ovf_ff[STEPS][l] || (dq_ff[STEPS][l] >= LIMIT);
         if (side_ff[STEPS].w_zero) begin
            quot_in[l] = $signed(dq_ff[STEPS][l]);
         end else if (neg_ff[STEPS][l]) begin
            quot_in[l] = big[l] ? $signed(LIMIT)
                                : $signed((~dq_ff[STEPS][l]) + COORD_WIDTH'(1));
         end else begin
            quot_in[l] = big[l] ? $signed(POS_MAX) : $signed(dq_ff[STEPS][l]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_fin_ff.valid <= 1'b0;
      end else if (advance) begin
         side_fin_ff <= side_ff[STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int l = 0; l < LANES; l++) begin
            quot_ff[l] <= quot_in[l];
         end
      end
   end

   assign side_out = side_fin_ff;
   assign quot_out = quot_ff;

endmodule

[rtl/vpp_viewport.sv]
// viewport scale stage and pixel truncate/saturate output register
module vpp_viewport import vpp_pkg::*; #(
   parameter int FRAC_BITS   = FRAC_BITS_DEFAULT,
   parameter int COORD_WIDTH = COORD_WIDTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  vtx_side_type                  side_in,
   input  logic signed [COORD_WIDTH-1:0] quot_in [LANES],
   input  logic [VIEWPORT_W-1:0]         viewport_width,
   input  logic [VIEWPORT_W-1:0]         viewport_height,
   output vtx_side_type                  side_out,
   output logic signed [PIXEL_W-1:0]     pixel_x,
   output logic signed [PIXEL_W-1:0]     pixel_y,
   output field_type                     depth_out
);

   localparam int ADD_W   = ((COORD_WIDTH > FRAC_BITS + 1) ? COORD_WIDTH : FRAC_BITS + 1) + 1;
   localparam int MUL_W   = ADD_W + VIEWPORT_W + 1;
   localparam int DEPTH_W = (ADD_W > FIELD_W) ? ADD_W : FIELD_W;
   localparam logic signed [ADD_W-1:0] ONE = ADD_W'(1) <<< FRAC_BITS;
   localparam logic signed [MUL_W-1:0] TRUNC_BIAS = (MUL_W'(1) <<< (FRAC_BITS + 1)) - MUL_W'(1);
   localparam logic signed [MUL_W-1:0] PIX_MAX = (MUL_W'(1) <<< (PIXEL_W - 1)) - MUL_W'(1);
   localparam logic signed [MUL_W-1:0] PIX_MIN = -PIX_MAX - MUL_W'(1);
   localparam logic signed [DEPTH_W-1:0] DEPTH_MAX =
      (DEPTH_W'(1) <<< (FIELD_W - 1)) - DEPTH_W'(1);
   localparam logic signed [DEPTH_W-1:0] DEPTH_MIN = -DEPTH_MAX - DEPTH_W'(1);

   function automatic logic signed [PIXEL_W-1:0] sat_pixel(input logic signed [MUL_W-1:0] v);
      logic signed [PIXEL_W-1:0] r;
      if (v > PIX_MAX) begin
         r = PIX_MAX[PIXEL_W-1:0];
      end else if (v < PIX_MIN) begin
         r = PIX_MIN[PIXEL_W-1:0];
      end else begin
         r = v[PIXEL_W-1:0];
      end
      return r;
   endfunction

   // scale stage
   logic signed [ADD_W-1:0]   ndc_x, ndc_y, ndc_z;
   logic signed [DEPTH_W-1:0] depth_wide;
   logic signed [MUL_W-1:0]   prod_x_in, prod_y_in, prod_x_ff, prod_y_ff;
   field_type                 depth_in, depth_ff;
   vtx_side_type              side_m_ff;

   always_comb begin
      ndc_x      = ADD_W'(quot_in[LANE_X]) + ONE;
      ndc_y      = ADD_W'(quot_in[LANE_Y]) + ONE;
      ndc_z      = ADD_W'(quot_in[LANE_Z]) + ONE;
      prod_x_in  = MUL_W'(ndc_x) * $signed({1'b0, viewport_width});
      prod_y_in  = MUL_W'(ndc_y) * $signed({1'b0, viewport_height});
      depth_wide = DEPTH_W'(ndc_z) >>> 1;
      if (depth_wide > DEPTH_MAX) begin
         depth_in = DEPTH_MAX[FIELD_W-1:0];
      end else if (depth_wide < DEPTH_MIN) begin
         depth_in = DEPTH_MIN[FIELD_W-1:0];
      end else begin
         depth_in = depth_wide[FIELD_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_m_ff.valid <= 1'b0;
      end else if (advance) begin
         side_m_ff <= side_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_x_ff <= prod_x_in;
         prod_y_ff <= prod_y_in;
         depth_ff  <= depth_in;
      end
   end

   // output stage: divide by two ones toward zero, clamp to pixel range
   logic signed [MUL_W-1:0]   biased_x, biased_y;
   logic signed [PIXEL_W-1:0] pixel_x_in, pixel_y_in, pixel_x_ff, pixel_y_ff;
   field_type                 depth_out_ff;
   vtx_side_type              side_out_ff;

   always_comb begin
      biased_x   = prod_x_ff[MUL_W-1] ? prod_x_ff + TRUNC_BIAS : prod_x_ff;
      biased_y   = prod_y_ff[MUL_W-1] ? prod_y_ff + TRUNC_BIAS : prod_y_ff;
      pixel_x_in = sat_pixel(biased_x >>> (FRAC_BITS + 1));
      pixel_y_in = sat_pixel(biased_y >>> (FRAC_BITS + 1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_out_ff.valid <= 1'b0;
      end else if (advance) begin
         side_out_ff <= side_m_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pixel_x_ff   <= pixel_x_in;
         pixel_y_ff   <= pixel_y_in;
         depth_out_ff <= depth_ff;
      end
   end

   assign side_out  = side_out_ff;
   assign pixel_x   = pixel_x_ff;
   assign pixel_y   = pixel_y_ff;
   assign depth_out = depth_out_ff;

endmodule

[rtl/vertex_perspective_projection.sv]
// vertex perspective projection top level: config registers and pipeline
//
// req carries one camera-space vertex (x, y, z, signed Q16.16 by default);
// a transfer happens when valid and ready are both high. rsp carries the
// screen pixel, the normalized depth, w and the zero-w flag for each vertex,
// in order, one result per vertex. csr writes the matrix terms and viewport
// size by index; ready is always high and every index names one of the eight registers.
// COORD_WIDTH + 6 register stages lie between req transfer and rsp valid:
// two for multiply and clip sums, one for divider setup, one per quotient
// bit in the divider, one for the sign and saturate step, one for viewport
// scaling and one output register.
// One vertex is accepted per cycle while rsp does not stall; the divider
// produces one quotient bit per stage for all three lanes at once.
// Reset clears all valid bits and loads the default matrix and a 320 by 200
// viewport. When rsp is stalled with a result waiting, the whole pipeline
// holds and req.ready drops in the same cycle; nothing is lost or repeated.
// Config is to be written only while the pipeline is empty.
module vertex_perspective_projection import vpp_pkg::*; #(
   parameter int FRAC_BITS   = FRAC_BITS_DEFAULT,
   parameter int COORD_WIDTH = COORD_WIDTH_DEFAULT
) (
   input logic       clock,
   input logic       reset,
   vpp_req_if.sink   req,
   vpp_rsp_if.source rsp,
   vpp_csr_if.sink   csr
);

   localparam field_type FIX_ONE = FIELD_W'(1) <<< FRAC_BITS;

   matrix_type              matrix_ff;
   logic [VIEWPORT_W-1:0]   viewport_width_ff;
   logic [VIEWPORT_W-1:0]   viewport_height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         matrix_ff <= '{x_scale: FIX_ONE, y_scale: FIX_ONE, y_from_depth: '0,
                        depth_from_x: '0, depth_scale: -FIX_ONE, depth_offset: '0};
         viewport_width_ff  <= VIEWPORT_WIDTH_RESET;
         viewport_height_ff <= VIEWPORT_HEIGHT_RESET;
      end else if (csr.valid) begin
         case (csr_index_type'(csr.index))
            CSR_X_SCALE:         matrix_ff.x_scale      <= csr.data;
            CSR_Y_SCALE:         matrix_ff.y_scale      <= csr.data;
            CSR_Y_FROM_DEPTH:    matrix_ff.y_from_depth <= csr.data;
            CSR_DEPTH_FROM_X:    matrix_ff.depth_from_x <= csr.data;
            CSR_DEPTH_SCALE:     matrix_ff.depth_scale  <= csr.data;
            CSR_DEPTH_OFFSET:    matrix_ff.depth_offset <= csr.data;
            CSR_VIEWPORT_WIDTH:  viewport_width_ff      <= csr.data[VIEWPORT_W-1:0];
            CSR_VIEWPORT_HEIGHT: viewport_height_ff     <= csr.data[VIEWPORT_W-1:0];
            default: ;
         endcase
      end
   end

   assign csr.ready = 1'b1;

   // global pipeline enable: move unless a finished result is held
   logic                          advance;
   vtx_side_type                  clip_side, quot_side, out_side;
   logic signed [COORD_WIDTH-1:0] clip [LANES];
   logic signed [COORD_WIDTH-1:0] quot [LANES];

   assign advance   = !out_side.valid || rsp.ready;
   assign req.ready = advance;

   vpp_transform #(
      .FRAC_BITS   (FRAC_BITS),
      .COORD_WIDTH (COORD_WIDTH)
   ) u_transform (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_valid (req.valid),
      .vertex_x (req.vertex_x),
      .vertex_y (req.vertex_y),
      .vertex_z (req.vertex_z),
      .matrix   (matrix_ff),
      .side_out (clip_side),
      .clip_out (clip)
   );

   vpp_divider #(
      .FRAC_BITS   (FRAC_BITS),
      .COORD_WIDTH (COORD_WIDTH)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .side_in  (clip_side),
      .clip_in  (clip),
      .side_out (quot_side),
      .quot_out (quot)
   );

   vpp_viewport #(
      .FRAC_BITS   (FRAC_BITS),
      .COORD_WIDTH (COORD_WIDTH)
   ) u_viewport (
      .clock           (clock),
      .reset           (reset),
      .advance         (advance),
      .side_in         (quot_side),
      .quot_in         (quot),
      .viewport_width  (viewport_width_ff),
      .viewport_height (viewport_height_ff),
      .side_out        (out_side),
      .pixel_x         (rsp.pixel_x),
      .pixel_y         (rsp.pixel_y),
      .depth_out       (rsp.depth_out)
   );

   assign rsp.valid      = out_side.valid;
   assign rsp.clip_w     = out_side.w;
   assign rsp.w_was_zero = out_side.w_zero;

endmodule
